@@ design/sct_pkg.sv @@
package sct_pkg;

  // character codes the tokenizer reacts to
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;

  // most results one item can cause
  localparam int MAX_RES = 3;

  // default depth of the queue between front and back
  localparam int QUEUE_DEPTH_DEF = 2;

  typedef enum logic [2:0] {
    KIND_ARG_CHAR  = 3'd0,
    KIND_ARG_END   = 3'd1,
    KIND_FILE_CHAR = 3'd2,
    KIND_FILE_END  = 3'd3,
    KIND_LINE_END  = 3'd4
  } kind_t;

  // one result
  typedef struct packed {
    logic [7:0] chr;
    kind_t      kind;
  } res_t;

  // all results of one item, cnt of them valid from entry 0
  typedef struct packed {
    logic [1:0]           cnt;
    res_t [MAX_RES-1:0]   r;
  } bundle_t;

endpackage

@@ design/sct_front.sv @@
module sct_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [7:0]        ch,
  input  logic              end_of_line,
  input  logic              q_full,
  output logic              q_push,
  output sct_pkg::bundle_t  q_data
);

  typedef enum logic [1:0] {
    ESC_NONE = 2'd0,
    ESC_BARE = 2'd1,
    ESC_DQ   = 2'd2
  } esc_t;

  typedef enum logic [1:0] {
    RD_NONE = 2'd0,
    RD_SKIP = 2'd1,
    RD_NAME = 2'd2
  } redir_t;

  // results gathered for one item, plus the open-word flag they affect
  typedef struct packed {
    logic [1:0]                         n;
    sct_pkg::res_t [sct_pkg::MAX_RES-1:0] r;
    logic                               tok;
  } acc_t;

  function automatic acc_t emit(acc_t a, logic [7:0] c, sct_pkg::kind_t k);
    acc_t b;
    b = a;
    if (b.n != 2'(sct_pkg::MAX_RES)) begin
      b.r[b.n].chr  = c;
      b.r[b.n].kind = k;
      b.n = b.n + 2'd1;
      if (k == sct_pkg::KIND_ARG_CHAR) begin
        b.tok = 1'b1;
      end
    end
    return b;
  endfunction

  function automatic acc_t close_word(acc_t a);
    acc_t b;
    b = a;
    if (b.tok) begin
      b = emit(b, 8'h00, sct_pkg::KIND_ARG_END);
    end
    b.tok = 1'b0;
    return b;
  endfunction

  logic   in_single_quote, in_single_quote_next;
  logic   in_double_quote, in_double_quote_next;
  esc_t   escape_mode, escape_mode_next;
  logic   held_one, held_one_next;
  redir_t redirect_mode, redirect_mode_next;
  logic   token_open;
  acc_t   acc;
  logic   do_plain;
  logic   accept;

  assign accept = push && !q_full;

  // classify the item, gather its results and the next state
  always_comb begin
    acc                  = '0;
    acc.tok              = token_open;
    in_single_quote_next = in_single_quote;
    in_double_quote_next = in_double_quote;
    escape_mode_next     = escape_mode;
    held_one_next        = held_one;
    redirect_mode_next   = redirect_mode;
    do_plain             = 1'b0;

    if (end_of_line) begin
      if (redirect_mode != RD_NONE) begin
        acc = emit(acc, 8'h00, sct_pkg::KIND_FILE_END);
      end else if (held_one) begin
        acc = emit(acc, sct_pkg::CH_ONE, sct_pkg::KIND_ARG_CHAR);
      end else if (escape_mode == ESC_DQ) begin
        acc = emit(acc, sct_pkg::CH_BSLASH, sct_pkg::KIND_ARG_CHAR);
      end
      acc = close_word(acc);
      acc = emit(acc, 8'h00, sct_pkg::KIND_LINE_END);
      in_single_quote_next = 1'b0;
      in_double_quote_next = 1'b0;
      escape_mode_next     = ESC_NONE;
      held_one_next        = 1'b0;
      redirect_mode_next   = RD_NONE;
      acc.tok              = 1'b0;
    end else if (redirect_mode == RD_SKIP) begin
      if (ch != sct_pkg::CH_SPACE) begin
        acc = emit(acc, ch, sct_pkg::KIND_FILE_CHAR);
        redirect_mode_next = RD_NAME;
      end
    end else if (redirect_mode != RD_NONE) begin
      if (ch == sct_pkg::CH_SPACE) begin
        acc = emit(acc, 8'h00, sct_pkg::KIND_FILE_END);
        redirect_mode_next = RD_NONE;
      end else begin
        acc = emit(acc, ch, sct_pkg::KIND_FILE_CHAR);
      end
    end else if (escape_mode == ESC_BARE) begin
      escape_mode_next = ESC_NONE;
      acc = emit(acc, ch, sct_pkg::KIND_ARG_CHAR);
    end else if (escape_mode == ESC_DQ) begin
      escape_mode_next = ESC_NONE;
      if (ch inside {sct_pkg::CH_DOLLAR, sct_pkg::CH_DQUOTE, sct_pkg::CH_BSLASH,
                     sct_pkg::CH_NL}) begin
        acc = emit(acc, ch, sct_pkg::KIND_ARG_CHAR);
      end else begin
        acc = emit(acc, sct_pkg::CH_BSLASH, sct_pkg::KIND_ARG_CHAR);
        acc = emit(acc, ch, sct_pkg::KIND_ARG_CHAR);
      end
    end else if (held_one) begin
      held_one_next = 1'b0;
      if (ch == sct_pkg::CH_GT) begin
        acc = close_word(acc);
        redirect_mode_next = RD_SKIP;
      end else begin
        acc = emit(acc, sct_pkg::CH_ONE, sct_pkg::KIND_ARG_CHAR);
        do_plain = 1'b1;
      end
    end else begin
      do_plain = 1'b1;
    end

    // ordinary character handling, quote state as it was before this item
    if (do_plain) begin
      if (ch == sct_pkg::CH_BSLASH) begin
        if (in_single_quote) begin
          acc = emit(acc, sct_pkg::CH_BSLASH, sct_pkg::KIND_ARG_CHAR);
        end else if (in_double_quote) begin
          escape_mode_next = ESC_DQ;
        end else begin
          escape_mode_next = ESC_BARE;
        end
      end else if (!in_single_quote && !in_double_quote && ch == sct_pkg::CH_ONE) begin
        held_one_next = 1'b1;
      end else if (!in_single_quote && !in_double_quote && ch == sct_pkg::CH_GT) begin
        acc = close_word(acc);
        redirect_mode_next = RD_SKIP;
      end else if (ch == sct_pkg::CH_SQUOTE && !in_double_quote) begin
        in_single_quote_next = !in_single_quote;
      end else if (ch == sct_pkg::CH_DQUOTE && !in_single_quote) begin
        in_double_quote_next = !in_double_quote;
      end else if (!in_single_quote && !in_double_quote && ch == sct_pkg::CH_SPACE) begin
        acc = close_word(acc);
      end else begin
        acc = emit(acc, ch, sct_pkg::KIND_ARG_CHAR);
      end
    end
  end

  // items with no result put nothing in the queue
  assign q_push     = accept && (acc.n != 2'd0);
  assign q_data.cnt = acc.n;
  assign q_data.r   = acc.r;

  // tokenizer state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_single_quote <= 1'b0;
      in_double_quote <= 1'b0;
      escape_mode     <= ESC_NONE;
      held_one        <= 1'b0;
      redirect_mode   <= RD_NONE;
      token_open      <= 1'b0;
    end else if (accept) begin
      in_single_quote <= in_single_quote_next;
      in_double_quote <= in_double_quote_next;
      escape_mode     <= escape_mode_next;
      held_one        <= held_one_next;
      redirect_mode   <= redirect_mode_next;
      token_open      <= acc.tok;
    end
  end

  // a pending backslash or held one only lives outside a filename
  a_esc_no_redir: assert property (@(posedge clk) disable iff (rst)
    (escape_mode != ESC_NONE) |-> (redirect_mode == RD_NONE && !held_one))
    else $error("backslash pending together with redirect or held one");

  a_held_no_redir: assert property (@(posedge clk) disable iff (rst)
    held_one |-> (redirect_mode == RD_NONE && !in_single_quote && !in_double_quote))
    else $error("held one outside the unquoted state");

  // an end of line item always leaves the reset state behind it
  a_eol_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && end_of_line) |=>
      (!token_open && !held_one && redirect_mode == RD_NONE && escape_mode == ESC_NONE))
    else $error("state not cleared after end of line");

  a_quotes_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(in_single_quote && in_double_quote))
    else $error("both quote modes active");

endmodule

@@ design/sct_queue.sv @@
module sct_queue #(
  parameter int DEPTH = sct_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  sct_pkg::bundle_t  wdata,
  input  logic              rd,
  output sct_pkg::bundle_t  rdata,
  output logic              full,
  output logic              valid
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  sct_pkg::bundle_t slots [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full  = (count == CW'(DEPTH));
  assign valid = (count != '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && valid;
  assign rdata = slots[rptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (do_rd) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

  // bundle storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wptr] <= wdata;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count beyond depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == '0 || count == CW'(DEPTH)) |-> (wptr == rptr))
    else $error("queue pointers disagree with count");

  a_no_empty_bundle: assert property (@(posedge clk) disable iff (rst)
    valid |-> (rdata.cnt != 2'd0))
    else $error("empty bundle in queue");

endmodule

@@ design/sct_back.sv @@
module sct_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  sct_pkg::bundle_t  q_data,
  output logic              q_pop,
  input  logic              pop,
  output logic              empty,
  output logic [7:0]        out_char,
  output logic [2:0]        kind,
  output logic              last_of_run
);

  logic       out_valid;
  logic [1:0] idx;
  logic       load;
  logic       is_last;

  // take the next result whenever the output register is free or drains
  assign load    = q_valid && (!out_valid || pop);
  assign is_last = (idx == q_data.cnt - 2'd1);
  assign q_pop   = load && is_last;
  assign empty   = !out_valid;

  // result walk and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= is_last ? 2'd0 : idx + 2'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char    <= q_data.r[idx].chr;
      kind        <= 3'(q_data.r[idx].kind);
      last_of_run <= is_last;
    end
  end

  a_idx_in_bundle: assert property (@(posedge clk) disable iff (rst)
    q_valid |-> (idx < q_data.cnt))
    else $error("result index past bundle end");

  a_idx_rests: assert property (@(posedge clk) disable iff (rst)
    !q_valid |-> (idx == 2'd0))
    else $error("result index left mid bundle");

  a_pop_last: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (out_valid && last_of_run))
    else $error("bundle retired without last result shown");

endmodule

@@ design/shell_command_tokenizer.sv @@
// Shell command tokenizer
//
// Input channel: one character per item on ch, or a terminator item with
// end_of_line set. An item is taken at a clock edge with push high and full
// low. Result channel: while empty is low the oldest result sits on out_char,
// kind and last_of_run; it is taken at an edge with pop high. Each item gives
// zero to three results, the last one flagged by last_of_run.
//
// The front classifies an item in the cycle it is taken and writes all of its
// results as one entry into a small queue; the back hands them out one per
// cycle through an output register while the receiver keeps popping. A result
// passes through the queue and then the output register before it reaches the
// ports. Items are taken one per cycle as long as the back keeps up; an item
// with several results holds the back longer and full rises when the queue
// fills. When the receiver stops popping, results wait in the output register
// and the queue, and full stops further items once the queue is full.
//
// Reset (rst, synchronous) clears the quote, escape, redirect and word state
// and empties the queue and output register.
module shell_command_tokenizer #(
  parameter int QUEUE_DEPTH = sct_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] ch,
  input  logic       end_of_line,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_char,
  output logic [2:0] kind,
  output logic       last_of_run
);

  logic             q_push;
  logic             q_pop;
  logic             q_valid;
  sct_pkg::bundle_t q_wdata;
  sct_pkg::bundle_t q_rdata;

  // tokenizer state and classification
  sct_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .ch          (ch),
    .end_of_line (end_of_line),
    .q_full      (full),
    .q_push      (q_push),
    .q_data      (q_wdata)
  );

  // result bundles between front and back
  sct_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_push),
    .wdata (q_wdata),
    .rd    (q_pop),
    .rdata (q_rdata),
    .full  (full),
    .valid (q_valid)
  );

  // one result per cycle to the output while the receiver keeps popping
  sct_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_data      (q_rdata),
    .q_pop       (q_pop),
    .pop         (pop),
    .empty       (empty),
    .out_char    (out_char),
    .kind        (kind),
    .last_of_run (last_of_run)
  );

endmodule
